[rtl/core/stt_pkg.sv]
// shared types, constants and helper functions of the source text tokenizer
// no dependencies; imported by every module of the block

package stt_pkg;

    localparam int POS_BITS = 16;
    localparam int LEN_BITS = 16;
    localparam int VAL_BITS = 31;
    localparam int QDEPTH   = 4;
    localparam int QAW      = $clog2(QDEPTH);

    localparam logic [VAL_BITS-1:0] INT_MAX_VAL = {VAL_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0] LEN_MAX     = {LEN_BITS{1'b1}};

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [3:0] {
        KIND_EOF      = 4'd0,
        KIND_EQ       = 4'd1,
        KIND_DOT      = 4'd2,
        KIND_SEMI     = 4'd3,
        KIND_LPAREN   = 4'd4,
        KIND_RPAREN   = 4'd5,
        KIND_INT      = 4'd6,
        KIND_IDENT    = 4'd7,
        KIND_NEW      = 4'd8,
        KIND_OBJECT   = 4'd9,
        KIND_NULL     = 4'd10,
        KIND_GC       = 4'd11,
        KIND_BAD      = 4'd12,
        KIND_OVERFLOW = 4'd13
    } kind_t;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_PUNCT,
        CLS_DIGIT,
        CLS_ALPHA,
        CLS_BAD
    } cls_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_DROP
    } mode_t;

    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
        cls_t       cls;
        kind_t      pkind;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_port_t;

    typedef struct packed {
        kind_t               kind;
        logic [VAL_BITS-1:0] int_value;
        logic [15:0]         start_pos;
        logic [LEN_BITS-1:0] token_length;
        logic [7:0]          bad_byte;
    } tok_t;

    // keyword k = 0 new, 1 Object, 2 null, 3 gc
    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] l;
        case (k)
            2'd0:    l = 3'd3;
            2'd1:    l = 3'd6;
            2'd2:    l = 3'd4;
            default: l = 3'd2;
        endcase
        return l;
    endfunction

    function automatic kind_t kw_kind(input logic [1:0] k);
        kind_t r;
        case (k)
            2'd0:    r = KIND_NEW;
            2'd1:    r = KIND_OBJECT;
            2'd2:    r = KIND_NULL;
            default: r = KIND_GC;
        endcase
        return r;
    endfunction

    // zero past the keyword's end, which no identifier byte matches
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            2'd0: begin
                case (i)
                    3'd0:    ch = 8'h6E;
                    3'd1:    ch = 8'h65;
                    3'd2:    ch = 8'h77;
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                case (i)
                    3'd0:    ch = 8'h4F;
                    3'd1:    ch = 8'h62;
                    3'd2:    ch = 8'h6A;
                    3'd3:    ch = 8'h65;
                    3'd4:    ch = 8'h63;
                    3'd5:    ch = 8'h74;
                    default: ch = 8'h00;
                endcase
            end
            2'd2: begin
                case (i)
                    3'd0:    ch = 8'h6E;
                    3'd1:    ch = 8'h75;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h6C;
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                case (i)
                    3'd0:    ch = 8'h67;
                    3'd1:    ch = 8'h63;
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    // drop keywords whose byte at idx differs from c
    function automatic logic [3:0] kw_narrow(input logic [3:0] cand,
                                             input logic [LEN_BITS-1:0] idx,
                                             input logic [7:0] c);
        logic [3:0] r;
        r = cand;
        for (int k = 0; k < 4; k++) begin
            if (idx >= LEN_BITS'(6) || kw_char(2'(k), idx[2:0]) != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic kind_t ident_kind(input logic [3:0] cand,
                                         input logic [LEN_BITS-1:0] len);
        kind_t r;
        r = KIND_IDENT;
        for (int k = 3; k >= 0; k--) begin
            if (cand[k] && len == LEN_BITS'(kw_len(2'(k)))) begin
                r = kw_kind(2'(k));
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/source_text_tokenizer_top.sv]
// top level of the source text tokenizer: front end, queue and scanner
// depends on stt_pkg, stt_front, stt_fifo, stt_back
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_op, s_char_code
//  m_       out        m_valid/m_ready    m_kind, m_int_value, m_start_pos,
//                                         m_token_length, m_bad_byte, m_last_of_run
//
// one item per cycle while m_ready holds and each item gives at most one token; an item that gives
// two tokens holds the scanner until both have passed the single output register.
// a taken item's result passes through the queue, then the output register.
// the four-entry queue lets s_ keep flowing while m_ is stalled, until the queue is full.
// reset is synchronous on aresetn and clears queue, scanner state and m_valid.

module source_text_tokenizer_top
    import stt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [7:0]          s_char_code,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_kind,
    output logic [VAL_BITS-1:0] m_int_value,
    output logic [15:0]         m_start_pos,
    output logic [LEN_BITS-1:0] m_token_length,
    output logic [7:0]          m_bad_byte,
    output logic                m_last_of_run
);

    q_port_t q_push;
    q_port_t q_head;
    logic    q_full;
    logic    q_pop;

    stt_front u_front (
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_char_code (s_char_code),
        .q_full      (q_full),
        .q_push      (q_push)
    );

    stt_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    stt_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_int_value    (m_int_value),
        .m_start_pos    (m_start_pos),
        .m_token_length (m_token_length),
        .m_bad_byte     (m_bad_byte),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

[rtl/core/stt_front.sv]
// front end: input handshake and byte classification into the token queue
// depends on stt_pkg

module stt_front
    import stt_pkg::*;
(
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_char_code,
    input  logic       q_full,
    output q_port_t    q_push
);

    cls_t  cls;
    kind_t pkind;

    always_comb begin
        pkind = KIND_EOF;
        unique case (s_char_code) inside
            [8'd9:8'd13], 8'd32:                      cls = CLS_SPACE;
            [8'h30:8'h39]:                            cls = CLS_DIGIT;
            [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER:   cls = CLS_ALPHA;
            CH_EQ: begin
                cls   = CLS_PUNCT;
                pkind = KIND_EQ;
            end
            CH_DOT: begin
                cls   = CLS_PUNCT;
                pkind = KIND_DOT;
            end
            CH_SEMI: begin
                cls   = CLS_PUNCT;
                pkind = KIND_SEMI;
            end
            CH_LPAREN: begin
                cls   = CLS_PUNCT;
                pkind = KIND_LPAREN;
            end
            CH_RPAREN: begin
                cls   = CLS_PUNCT;
                pkind = KIND_RPAREN;
            end
            default:                                  cls = CLS_BAD;
        endcase
    end

    // hold off while in reset so nothing lands in the queue early
    assign s_ready = aresetn && !q_full;

    always_comb begin
        q_push.valid           = s_valid && s_ready;
        q_push.entry.op        = s_op;
        q_push.entry.char_code = s_char_code;
        q_push.entry.cls       = cls;
        q_push.entry.pkind     = pkind;
    end

endmodule

[rtl/core/stt_fifo.sv]
// short queue of classified items between front end and scanner
// depends on stt_pkg

module stt_fifo
    import stt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  q_port_t q_push,
    output logic    q_full,
    output q_port_t q_head,
    input  logic    q_pop
);

    q_entry_t         mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             do_pop;

    assign q_full       = count_reg == (QAW+1)'(QDEPTH);
    assign q_head.valid = count_reg != '0;
    assign q_head.entry = mem_reg[rd_ptr_reg];
    assign do_pop       = q_pop && q_head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.valid) begin
            wr_ptr_next = wr_ptr_reg + QAW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + QAW'(1);
        end
        if (q_push.valid && !do_pop) begin
            count_next = count_reg + (QAW+1)'(1);
        end else if (!q_push.valid && do_pop) begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.valid) begin
            mem_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule

[rtl/core/stt_back.sv]
// back end: scanner state, token assembly and the result output register
// depends on stt_pkg

module stt_back
    import stt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  q_port_t             q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_kind,
    output logic [VAL_BITS-1:0] m_int_value,
    output logic [15:0]         m_start_pos,
    output logic [LEN_BITS-1:0] m_token_length,
    output logic [7:0]          m_bad_byte,
    output logic                m_last_of_run
);

    mode_t               mode_reg, mode_next;
    logic [VAL_BITS-1:0] acc_reg, acc_next;
    logic                ovf_reg, ovf_next;
    logic [15:0]         start_reg, start_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [3:0]          cand_reg, cand_next;
    logic                phase_reg, phase_next;
    logic                m_valid_reg, m_valid_next;
    tok_t                out_reg;
    logic                last_reg;

    q_entry_t              e;
    logic                  is_digit, is_more;
    logic [VAL_BITS+3:0]   acc_mul;
    logic                  acc_big;
    logic [LEN_BITS-1:0]   len_grow;
    logic [POS_BITS+15:0]  pos_ext;
    logic [15:0]           pos16;
    logic                  cont_num, cont_ident;
    logic                  flush_valid;
    tok_t                  flush_tok;
    mode_t                 mode_after;
    logic                  byte_valid;
    tok_t                  byte_tok;
    logic [1:0]            n_res;
    tok_t                  res0;
    logic                  out_free, fire, emit;

    assign e          = q_head.entry;
    assign is_digit   = e.cls == CLS_DIGIT;
    assign is_more    = is_digit || e.cls == CLS_ALPHA;
    assign acc_mul    = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                        + (VAL_BITS+4)'(e.char_code[3:0]);
    assign acc_big    = acc_mul > {4'b0, INT_MAX_VAL};
    assign len_grow   = (len_reg == LEN_MAX) ? len_reg : len_reg + LEN_BITS'(1);
    assign pos_ext    = {16'b0, pos_reg};
    assign pos16      = pos_ext[15:0];
    assign cont_num   = e.op == OP_BYTE && mode_reg == MODE_NUM && is_digit;
    assign cont_ident = e.op == OP_BYTE && mode_reg == MODE_IDENT && is_more;

    // pending token that this item closes
    always_comb begin
        flush_valid            = 1'b0;
        flush_tok              = '0;
        flush_tok.start_pos    = start_reg;
        flush_tok.token_length = len_reg;
        mode_after             = mode_reg;
        if (!cont_num && !cont_ident) begin
            if (mode_reg == MODE_NUM) begin
                flush_valid = 1'b1;
                if (ovf_reg) begin
                    flush_tok.kind = KIND_OVERFLOW;
                    mode_after     = MODE_DROP;
                end else begin
                    flush_tok.kind      = KIND_INT;
                    flush_tok.int_value = acc_reg;
                    mode_after          = MODE_IDLE;
                end
            end else if (mode_reg == MODE_IDENT) begin
                flush_valid    = 1'b1;
                flush_tok.kind = ident_kind(cand_reg, len_reg);
                mode_after     = MODE_IDLE;
            end
        end
    end

    // token made by the item itself: eof, a punctuator or a bad byte
    always_comb begin
        byte_valid = 1'b0;
        byte_tok   = '0;
        if (e.op == OP_END) begin
            byte_valid    = 1'b1;
            byte_tok.kind = KIND_EOF;
        end else if (!cont_num && !cont_ident && mode_after == MODE_IDLE) begin
            byte_tok.start_pos    = pos16;
            byte_tok.token_length = LEN_BITS'(1);
            if (e.cls == CLS_PUNCT) begin
                byte_valid    = 1'b1;
                byte_tok.kind = e.pkind;
            end else if (e.cls == CLS_BAD) begin
                byte_valid        = 1'b1;
                byte_tok.kind     = KIND_BAD;
                byte_tok.bad_byte = e.char_code;
            end
        end
    end

    assign n_res = 2'(flush_valid) + 2'(byte_valid);
    assign res0  = flush_valid ? flush_tok : byte_tok;

    // next scanner state, taken when the item leaves the queue
    always_comb begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        start_next = start_reg;
        len_next   = len_reg;
        cand_next  = cand_reg;
        pos_next   = pos_reg + POS_BITS'(1);
        if (e.op == OP_END) begin
            mode_next  = MODE_IDLE;
            acc_next   = '0;
            ovf_next   = 1'b0;
            start_next = '0;
            len_next   = '0;
            cand_next  = '0;
            pos_next   = '0;
        end else if (cont_num) begin
            if (ovf_reg || acc_big) begin
                ovf_next = 1'b1;
                acc_next = INT_MAX_VAL;
            end else begin
                acc_next = acc_mul[VAL_BITS-1:0];
            end
            len_next = len_grow;
        end else if (cont_ident) begin
            cand_next = kw_narrow(cand_reg, len_reg, e.char_code);
            len_next  = len_grow;
        end else begin
            mode_next = mode_after;
            if (mode_after == MODE_IDLE) begin
                if (e.cls == CLS_DIGIT) begin
                    mode_next  = MODE_NUM;
                    start_next = pos16;
                    len_next   = LEN_BITS'(1);
                    ovf_next   = 1'b0;
                    acc_next   = VAL_BITS'(e.char_code[3:0]);
                end else if (e.cls == CLS_ALPHA) begin
                    mode_next  = MODE_IDENT;
                    start_next = pos16;
                    len_next   = LEN_BITS'(1);
                    ovf_next   = 1'b0;
                    cand_next  = kw_narrow(4'hF, '0, e.char_code);
                end else if (e.cls == CLS_BAD) begin
                    mode_next = MODE_DROP;
                end
            end
        end
    end

    // items with no result move on even when the output register is full
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = q_head.valid && (n_res == 2'd0 || out_free);
    assign emit     = fire && n_res != 2'd0;
    assign q_pop    = fire && (n_res != 2'd2 || phase_reg);

    always_comb begin
        phase_next = phase_reg;
        if (q_pop) begin
            phase_next = 1'b0;
        end else if (fire && n_res == 2'd2) begin
            phase_next = 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            start_reg   <= '0;
            len_reg     <= '0;
            pos_reg     <= '0;
            cand_reg    <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                mode_reg  <= mode_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                pos_reg   <= pos_next;
                cand_reg  <= cand_next;
            end
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // second of two results is the item's own token
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg  <= (n_res == 2'd2 && phase_reg) ? byte_tok : res0;
            last_reg <= n_res == 2'd1 || phase_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_int_value    = out_reg.int_value;
    assign m_start_pos    = out_reg.start_pos;
    assign m_token_length = out_reg.token_length;
    assign m_bad_byte     = out_reg.bad_byte;
    assign m_last_of_run  = last_reg;

endmodule

[bench/testbench.sv]
// self-checking testbench of source_text_tokenizer_top: a byte-stream tokenizer predictor
// checks every token transfer; needs stt_pkg and the tokenizer rtl only

module testbench import stt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       op;
        logic [7:0] code;
    } src_item_t;

    typedef struct {
        kind_t               kind;
        logic [VAL_BITS-1:0] value;
        logic [15:0]         start;
        logic [LEN_BITS-1:0] len;
        logic [7:0]          bad;
        logic                last;
    } token_rec_t;

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic                s_op        = OP_BYTE;
    logic [7:0]          s_char_code = 8'h00;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [3:0]          m_kind;
    logic [VAL_BITS-1:0] m_int_value;
    logic [15:0]         m_start_pos;
    logic [LEN_BITS-1:0] m_token_length;
    logic [7:0]          m_bad_byte;
    logic                m_last_of_run;

    src_item_t  source_items[$];
    token_rec_t expected_tokens[$];
    token_rec_t item_tokens[$];
    src_item_t  next_item;

    int   items_pushed    = 0;
    int   items_accepted  = 0;
    int   error_count     = 0;
    int   stall_left      = 0;
    bit   long_stall_done = 1'b0;
    logic s_took          = 1'b0;

    // shadow scanner state
    mode_t               scan_state = MODE_IDLE;
    logic [VAL_BITS-1:0] num_acc    = '0;
    logic                num_ovf    = 1'b0;
    logic [15:0]         tok_start  = '0;
    logic [LEN_BITS-1:0] tok_len    = '0;
    logic [15:0]         next_pos   = '0;
    logic [3:0]          kw_live    = '0;

    string keyword_text[4]   = '{"new", "Object", "null", "gc"};
    kind_t keyword_kind[4]   = '{KIND_NEW, KIND_OBJECT, KIND_NULL, KIND_GC};
    logic [7:0] punct_codes[5] = '{CH_EQ, CH_DOT, CH_SEMI, CH_LPAREN, CH_RPAREN};
    logic [7:0] blank_codes[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    string word_start_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string word_char_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    source_text_tokenizer_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_char_code    (s_char_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_int_value    (m_int_value),
        .m_start_pos    (m_start_pos),
        .m_token_length (m_token_length),
        .m_bad_byte     (m_bad_byte),
        .m_last_of_run  (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_start(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic logic [3:0] narrow_keywords(logic [3:0] live, logic [LEN_BITS-1:0] idx,
                                                   logic [7:0] c);
        for (int k = 0; k < 4; k++) begin
            if (idx >= keyword_text[k].len() || keyword_text[k][idx] != c) begin
                live[k] = 1'b0;
            end
        end
        return live;
    endfunction

    function automatic void push_token(kind_t k, logic [VAL_BITS-1:0] v, logic [15:0] st,
                                       logic [LEN_BITS-1:0] ln, logic [7:0] b);
        token_rec_t t;
        t.kind  = k;
        t.value = v;
        t.start = st;
        t.len   = ln;
        t.bad   = b;
        t.last  = 1'b0;
        item_tokens.insert(item_tokens.size(), t);
    endfunction

    function automatic void flush_pending();
        kind_t k;
        if (scan_state == MODE_NUM) begin
            if (num_ovf) begin
                push_token(KIND_OVERFLOW, '0, tok_start, tok_len, 8'h00);
                scan_state = MODE_DROP;
            end else begin
                push_token(KIND_INT, num_acc, tok_start, tok_len, 8'h00);
                scan_state = MODE_IDLE;
            end
        end else if (scan_state == MODE_IDENT) begin
            k = KIND_IDENT;
            // lowest keyword index wins
            for (int i = 3; i >= 0; i--) begin
                if (kw_live[i] && tok_len == keyword_text[i].len()) begin
                    k = keyword_kind[i];
                end
            end
            push_token(k, '0, tok_start, tok_len, 8'h00);
            scan_state = MODE_IDLE;
        end
    endfunction

    function automatic void start_run(mode_t m);
        scan_state = m;
        tok_start  = next_pos;
        tok_len    = LEN_BITS'(1);
        num_ovf    = 1'b0;
    endfunction

    // works out the tokens one accepted item gives and queues them
    function automatic void tokenize_item(logic op, logic [7:0] ch);
        longint unsigned grown;
        item_tokens.delete();
        if (op == OP_END) begin
            flush_pending();
            push_token(KIND_EOF, '0, '0, '0, 8'h00);
            scan_state = MODE_IDLE;
            num_acc    = '0;
            num_ovf    = 1'b0;
            tok_start  = '0;
            tok_len    = '0;
            next_pos   = '0;
            kw_live    = '0;
        end else begin
            if (scan_state == MODE_NUM && is_digit_ch(ch)) begin
                grown = longint'(num_acc) * 10 + longint'(ch - "0");
                if (num_ovf || grown > longint'(INT_MAX_VAL)) begin
                    num_ovf = 1'b1;
                    num_acc = INT_MAX_VAL;
                end else begin
                    num_acc = VAL_BITS'(grown);
                end
                if (tok_len != LEN_MAX) tok_len++;
            end else if (scan_state == MODE_IDENT && (is_word_start(ch) || is_digit_ch(ch))) begin
                kw_live = narrow_keywords(kw_live, tok_len, ch);
                if (tok_len != LEN_MAX) tok_len++;
            end else if (scan_state != MODE_DROP) begin
                flush_pending();
                if (scan_state == MODE_IDLE) begin
                    case (ch)
                        CH_EQ:     push_token(KIND_EQ, '0, next_pos, LEN_BITS'(1), 8'h00);
                        CH_DOT:    push_token(KIND_DOT, '0, next_pos, LEN_BITS'(1), 8'h00);
                        CH_SEMI:   push_token(KIND_SEMI, '0, next_pos, LEN_BITS'(1), 8'h00);
                        CH_LPAREN: push_token(KIND_LPAREN, '0, next_pos, LEN_BITS'(1), 8'h00);
                        CH_RPAREN: push_token(KIND_RPAREN, '0, next_pos, LEN_BITS'(1), 8'h00);
                        default: begin
                            if (is_digit_ch(ch)) begin
                                start_run(MODE_NUM);
                                num_acc = VAL_BITS'(ch - "0");
                            end else if (is_word_start(ch)) begin
                                start_run(MODE_IDENT);
                                kw_live = narrow_keywords(4'hF, '0, ch);
                            end else if (!is_blank(ch)) begin
                                push_token(KIND_BAD, '0, next_pos, LEN_BITS'(1), ch);
                                scan_state = MODE_DROP;
                            end
                        end
                    endcase
                end
            end
            next_pos++;
        end
        if (item_tokens.size() != 0) begin
            item_tokens[item_tokens.size() - 1].last = 1'b1;
        end
        foreach (item_tokens[i]) expected_tokens.insert(expected_tokens.size(), item_tokens[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // quiet window in the middle of the random part: no idling on either side
    function automatic bit roll_idle();
        if (items_accepted >= 800 && items_accepted < 1100) return 1'b0;
        return $urandom_range(99) < 32;
    endfunction

    // driver: next item at the falling edge once the current one has transferred
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (source_items.size() != 0 && !roll_idle()) begin
                next_item = source_items.pop_front();
                s_valid     <= 1'b1;
                s_op        <= next_item.op;
                s_char_code <= next_item.code;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random idling plus one long hold-off so the input backs up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!long_stall_done && items_accepted >= 300) begin
                long_stall_done = 1'b1;
                stall_left = 250;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !roll_idle();
            end
        end
    end

    always @(posedge aclk) begin : monitor
        token_rec_t want;
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            tokenize_item(s_op, s_char_code);
            items_accepted <= items_accepted + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                $error("token transfer with none expected: kind %0d start %0d",
                       m_kind, m_start_pos);
                error_count++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_kind));
                check_field("int_value", 32'(want.value), 32'(m_int_value));
                check_field("start_pos", 32'(want.start), 32'(m_start_pos));
                check_field("token_length", 32'(want.len), 32'(m_token_length));
                check_field("bad_byte", 32'(want.bad), 32'(m_bad_byte));
                check_field("last_of_run", 32'(want.last), 32'(m_last_of_run));
            end
        end
    end

    task automatic push_item(logic op, logic [7:0] code);
        src_item_t it;
        it.op   = op;
        it.code = code;
        source_items.insert(source_items.size(), it);
        items_pushed++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_item(OP_BYTE, s[i]);
    endtask

    task automatic push_end();
        push_item(OP_END, 8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] pick_char(string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // one source: mostly well-formed tokens with random content, a little noise
    task automatic add_random_source();
        int    pick;
        int    kw;
        string word;
        repeat ($urandom_range(1, 24)) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                push_item(OP_BYTE, punct_codes[$urandom_range(4)]);
            end else if (pick < 27) begin
                push_item(OP_BYTE, blank_codes[$urandom_range(5)]);
            end else if (pick < 55) begin
                case ($urandom_range(7))
                    0:       word = "2147483647";
                    1:       word = "2147483648";
                    2:       word = $sformatf("%0d%0d", $urandom_range(1, 9), $urandom);
                    default: word = $sformatf("%0d", $urandom >> $urandom_range(0, 31));
                endcase
                if ($urandom_range(9) == 0) word = {"0", word};
                push_text(word);
            end else if (pick < 97) begin
                kw = $urandom_range(3);
                case ($urandom_range(4))
                    0: begin
                        push_text(keyword_text[kw].substr(0,
                                  $urandom_range(0, keyword_text[kw].len() - 1)));
                    end
                    1: begin
                        push_text(keyword_text[kw]);
                        repeat ($urandom_range(1, 3)) push_item(OP_BYTE, pick_char(word_char_set));
                    end
                    2: begin
                        push_item(OP_BYTE, pick_char(word_start_set));
                        repeat ($urandom_range(0, 7)) push_item(OP_BYTE, pick_char(word_char_set));
                    end
                    default: push_text(keyword_text[kw]);
                endcase
            end else begin
                push_item(OP_BYTE, 8'($urandom_range(255)));
            end
            if ($urandom_range(1) == 0) push_item(OP_BYTE, 8'h20);
        end
        push_end();
    endtask

    task automatic wait_drained();
        while (items_accepted != items_pushed || expected_tokens.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        int random_goal;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // keyword ended by punctuation, integer ended by punctuation,
        // identifier ended by a bad byte, then dropping until the end
        push_text("gc(");
        push_text(" 12)");
        push_item(OP_BYTE, "x");
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_BYTE, "a");
        push_end();
        // integer above the signed maximum, its terminator dropped
        push_text("9999999999;");
        push_end();
        wait_drained();

        random_goal = items_pushed + 2000;
        while (items_pushed < random_goal) add_random_source();
        wait_drained();

        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
